>>> design/dsfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsfe_pkg;

   localparam logic [7:0] FRAME_END  = 8'hC0;
   localparam logic [7:0] FRAME_ESC  = 8'hDB;
   localparam logic [7:0] ESC_OF_END = 8'hDC;
   localparam logic [7:0] ESC_OF_ESC = 8'hDD;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_BYTE   = 1'b1;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_SERIAL = 1'b1;

   // one result word without its last flag
   typedef struct packed {
      logic        kind;
      logic [15:0] ack_app_id;
      logic [15:0] ack_id;
      logic [7:0]  out_byte;
   } word_type;

   function automatic word_type ack_word(input logic [15:0] app, input logic [15:0] pid);
      word_type w;
      w.kind       = KIND_ACK;
      w.ack_app_id = app;
      w.ack_id     = pid;
      w.out_byte   = 8'h00;
      return w;
   endfunction

   function automatic word_type serial_word(input logic [7:0] b);
      word_type w;
      w.kind       = KIND_SERIAL;
      w.ack_app_id = 16'h0000;
      w.ack_id     = 16'h0000;
      w.out_byte   = b;
      return w;
   endfunction

endpackage

`default_nettype wire

>>> design/dsfe_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dsfe_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] app_id;
   logic [15:0] packet_id;
   logic [7:0]  pkt_len;
   logic [7:0]  data_byte;

   modport source (output valid, op, app_id, packet_id, pkt_len, data_byte, input ready);
   modport sink (input valid, op, app_id, packet_id, pkt_len, data_byte, output ready);
endinterface

interface dsfe_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] ack_app_id;
   logic [15:0] ack_id;
   logic [7:0]  out_byte;
   logic        last;

   modport source (output valid, kind, ack_app_id, ack_id, out_byte, last, input ready);
   modport sink (input valid, kind, ack_app_id, ack_id, out_byte, last, output ready);
endinterface

`default_nettype wire

>>> design/dedup_slip_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Duplicate-filtering SLIP framer between a radio side and a serial line.
// req_chan carries header words (op 0: app_id, packet_id, pkt_len) and payload
// byte words (op 1: data_byte). rsp_chan returns acknowledges (kind 0) and
// encoded serial bytes (kind 1); last marks the final result of one req word.
// A header gives an ack, and, if its id pair is not in the history ring, arms
// forwarding for pkt_len bytes (or emits the frame end at once for length 0).
// Payload bytes are escaped while armed, the last counted one is followed by
// the frame end; bytes that are not armed give no result.
// A word taken into the input stage moves on to the result stage (the output
// register) before its first result shows. Each req word holds the output
// stage until its last result is taken; a word with no results passes the
// input stage without entering it. The output register sets the rate: one
// word per cycle for single-result words while the receiver is ready.
// The history lookup compares all ring entries in parallel, combinationally.
// A new req word is taken while results of the previous one are still
// waiting. Reset clears the ring, the write position and the armed state.
// When the receiver stalls, the current result holds and the input stage
// fills and then drops ready.
module dedup_slip_frame_encoder_unit
   import dsfe_pkg::*;
#(
   parameter int HISTORY_DEPTH = 20
) (
   input  logic        clock,
   input  logic        reset,
   dsfe_req_if.sink    req_chan,
   dsfe_rsp_if.source  rsp_chan
);

   // input stage
   logic        a_valid_ff, a_valid_in;
   logic        a_op_ff;
   logic [15:0] a_app_ff;
   logic [15:0] a_pid_ff;
   logic [7:0]  a_len_ff;
   logic [7:0]  a_byte_ff;

   // result stage
   logic        b_valid_ff;
   word_type    b_words_ff [3];
   logic [1:0]  b_idx_ff;
   logic [1:0]  b_lastidx_ff;

   // framer state
   logic        fwd_ff, fwd_in;
   logic [7:0]  left_ff, left_in;

   logic        accept;
   logic        a_advance;
   logic        b_fire;
   logic        b_done;
   logic        seen;
   logic        hist_wr;

   word_type    w0, w1, w2;
   logic [1:0]  n_lastidx;
   logic        has_word;
   logic        escaped;
   logic        frame_done;
   logic [7:0]  left_dec;

   assign b_fire    = b_valid_ff && rsp_chan.ready;
   assign b_done    = b_fire && (b_idx_ff == b_lastidx_ff);
   assign a_advance = a_valid_ff && (!b_valid_ff || b_done);
   assign req_chan.ready = !a_valid_ff || a_advance;
   assign accept    = req_chan.valid && req_chan.ready;

   dsfe_history #(
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock (clock),
      .reset (reset),
      .key   ({a_app_ff, a_pid_ff}),
      .wr_en (hist_wr),
      .seen  (seen)
   );

   assign left_dec = left_ff - 8'd1;

   always_comb begin
      w0         = ack_word(a_app_ff, a_pid_ff);
      w1         = serial_word(FRAME_END);
      w2         = serial_word(FRAME_END);
      n_lastidx  = 2'd0;
      has_word   = 1'b0;
      fwd_in     = fwd_ff;
      left_in    = left_ff;
      hist_wr    = 1'b0;
      escaped    = 1'b0;
      frame_done = 1'b0;
      if (a_op_ff == OP_HEADER) begin
         has_word = 1'b1;
         fwd_in   = 1'b0;
         left_in  = 8'd0;
         if (!seen) begin
            hist_wr = a_advance;
            if (a_len_ff == 8'd0) begin
               n_lastidx = 2'd1;
            end else begin
               fwd_in  = 1'b1;
               left_in = a_len_ff;
            end
         end
      end else begin
         if (!fwd_ff || left_ff == 8'd0) begin
            fwd_in = 1'b0;
         end else begin
            has_word   = 1'b1;
            escaped    = (a_byte_ff == FRAME_ESC) || (a_byte_ff == FRAME_END);
            frame_done = (left_dec == 8'd0);
            left_in    = left_dec;
            if (frame_done) begin
               fwd_in = 1'b0;
            end
            if (escaped) begin
               w0 = serial_word(FRAME_ESC);
               w1 = serial_word((a_byte_ff == FRAME_ESC) ? ESC_OF_ESC : ESC_OF_END);
            end else begin
               w0 = serial_word(a_byte_ff);
            end
            // frame end lands after the escape pair or right after the byte
            n_lastidx = 2'({1'b0, escaped}) + 2'({1'b0, frame_done});
         end
      end
   end

   always_comb begin
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_op_ff   <= req_chan.op;
         a_app_ff  <= req_chan.app_id;
         a_pid_ff  <= req_chan.packet_id;
         a_len_ff  <= req_chan.pkt_len;
         a_byte_ff <= req_chan.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= 1'b0;
         left_ff <= 8'd0;
      end else if (a_advance) begin
         fwd_ff  <= fwd_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_idx_ff     <= 2'd0;
         b_lastidx_ff <= 2'd0;
      end else if (a_advance && has_word) begin
         b_valid_ff   <= 1'b1;
         b_idx_ff     <= 2'd0;
         b_lastidx_ff <= n_lastidx;
      end else if (b_done) begin
         b_valid_ff <= 1'b0;
      end else if (b_fire) begin
         b_idx_ff <= b_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance && has_word) begin
         b_words_ff[0] <= w0;
         b_words_ff[1] <= w1;
         b_words_ff[2] <= w2;
      end
   end

   word_type rsp_word;

   always_comb begin
      case (b_idx_ff)
         2'd0:    rsp_word = b_words_ff[0];
         2'd1:    rsp_word = b_words_ff[1];
         default: rsp_word = b_words_ff[2];
      endcase
   end

   assign rsp_chan.valid      = b_valid_ff;
   assign rsp_chan.kind       = rsp_word.kind;
   assign rsp_chan.ack_app_id = rsp_word.ack_app_id;
   assign rsp_chan.ack_id     = rsp_word.ack_id;
   assign rsp_chan.out_byte   = rsp_word.out_byte;
   assign rsp_chan.last       = (b_idx_ff == b_lastidx_ff);

endmodule

`default_nettype wire

>>> design/dsfe_history.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfe_history #(
   parameter int DEPTH = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] key,
   input  logic        wr_en,
   output logic        seen
);

   localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0]       ring_ff [DEPTH];
   logic [HEAD_W-1:0] head_ff;
   logic [HEAD_W-1:0] head_in;
   logic [DEPTH-1:0]  hit;

   // every entry has its own comparator
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = (ring_ff[i] == key);
      end
   end

   assign seen = |hit;

   always_comb begin
      if (head_ff == HEAD_W'(DEPTH - 1)) begin
         head_in = '0;
      end else begin
         head_in = head_ff + HEAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            ring_ff[i] <= 32'h0000_0000;
         end
      end else if (wr_en) begin
         head_ff <= head_in;
         for (int i = 0; i < DEPTH; i++) begin
            if (head_ff == HEAD_W'(i)) begin
               ring_ff[i] <= key;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> design/dsfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfe_checker
   import dsfe_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic [15:0] rsp_ack_app_id,
   input wire logic [15:0] rsp_ack_id,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last
);

   // nothing can come out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_ack_app_id) && $stable(rsp_ack_id) &&
         $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // the rest of one word's results follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside the results of one word");

   // an escape byte is always followed by its code
   a_escape_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_SERIAL && rsp_out_byte == FRAME_ESC
      |=> rsp_kind == KIND_SERIAL &&
         (rsp_out_byte == ESC_OF_ESC || rsp_out_byte == ESC_OF_END))
      else $error("escape byte not followed by an escape code");

   // the input side stalls only while a result is held at the output
   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled while output is empty");

endmodule

bind dedup_slip_frame_encoder_unit dsfe_checker u_dsfe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_ack_app_id (rsp_chan.ack_app_id),
   .rsp_ack_id     (rsp_chan.ack_id),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_last       (rsp_chan.last)
);

`default_nettype wire
